@@ sv/assert_macros.svh @@
// Assertion macros used by scan_set1_key_decoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while rst is high.
`define SSKD_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on clock, off while reset is high.
`define SSKD_ASSERT(lbl, prop, msg) \
   `SSKD_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

@@ sv/sskd_pkg.sv @@
// Types, byte codes and keymap for the scan code set 1 key decoder.
// Depends on nothing; used by scan_set1_key_decoder.
`default_nettype none

package sskd_pkg;

   localparam logic [7:0] EXT_PREFIX   = 8'hE0;
   localparam logic [7:0] PAUSE_PREFIX = 8'hE1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_EXT  = 3'd1,
      PH_P5   = 3'd2,
      PH_P4   = 3'd3,
      PH_P3   = 3'd4,
      PH_P2   = 3'd5,
      PH_P1   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] scan_byte;
      logic       shift_held;
   } req_type;

   typedef struct packed {
      logic [6:0] key_code;
      logic       is_extended;
      logic       is_press;
      logic [6:0] ascii_char;
   } rsp_type;

   function automatic logic is_ignored(input logic [7:0] b);
      return (b == 8'h00) || (b == 8'hAA) || (b == 8'hEE) || (b == 8'hFA) ||
             (b == 8'hFC) || (b == 8'hFD) || (b == 8'hFE) || (b == 8'hFF);
   endfunction

   // {unshifted, shifted}
   function automatic logic [13:0] key_pair(input logic [6:0] code);
      logic [13:0] pair;
      unique case (code)
         7'h02: pair = {7'h31, 7'h21};
         7'h03: pair = {7'h32, 7'h40};
         7'h04: pair = {7'h33, 7'h23};
         7'h05: pair = {7'h34, 7'h24};
         7'h06: pair = {7'h35, 7'h25};
         7'h07: pair = {7'h36, 7'h5E};
         7'h08: pair = {7'h37, 7'h26};
         7'h09: pair = {7'h38, 7'h2A};
         7'h0A: pair = {7'h39, 7'h28};
         7'h0B: pair = {7'h30, 7'h29};
         7'h0C: pair = {7'h2D, 7'h5F};
         7'h0D: pair = {7'h3D, 7'h2B};
         7'h0E: pair = {7'h08, 7'h08};
         7'h0F: pair = {7'h09, 7'h09};
         7'h10: pair = {7'h71, 7'h51};
         7'h11: pair = {7'h77, 7'h57};
         7'h12: pair = {7'h65, 7'h45};
         7'h13: pair = {7'h72, 7'h52};
         7'h14: pair = {7'h74, 7'h54};
         7'h15: pair = {7'h79, 7'h59};
         7'h16: pair = {7'h75, 7'h55};
         7'h17: pair = {7'h69, 7'h49};
         7'h18: pair = {7'h6F, 7'h4F};
         7'h19: pair = {7'h70, 7'h50};
         7'h1A: pair = {7'h5B, 7'h7B};
         7'h1B: pair = {7'h5D, 7'h7D};
         7'h1C: pair = {7'h0A, 7'h0A};
         7'h1E: pair = {7'h61, 7'h41};
         7'h1F: pair = {7'h73, 7'h53};
         7'h20: pair = {7'h64, 7'h44};
         7'h21: pair = {7'h66, 7'h46};
         7'h22: pair = {7'h67, 7'h47};
         7'h23: pair = {7'h68, 7'h48};
         7'h24: pair = {7'h6A, 7'h4A};
         7'h25: pair = {7'h6B, 7'h4B};
         7'h26: pair = {7'h6C, 7'h4C};
         7'h27: pair = {7'h3B, 7'h3A};
         7'h28: pair = {7'h27, 7'h22};
         7'h29: pair = {7'h60, 7'h7E};
         7'h2B: pair = {7'h5C, 7'h7C};
         7'h2C: pair = {7'h7A, 7'h5A};
         7'h2D: pair = {7'h78, 7'h58};
         7'h2E: pair = {7'h63, 7'h43};
         7'h2F: pair = {7'h76, 7'h56};
         7'h30: pair = {7'h62, 7'h42};
         7'h31: pair = {7'h6E, 7'h4E};
         7'h32: pair = {7'h6D, 7'h4D};
         7'h33: pair = {7'h2C, 7'h3C};
         7'h34: pair = {7'h2E, 7'h3E};
         7'h35: pair = {7'h2F, 7'h3F};
         7'h39: pair = {7'h20, 7'h20};
         default: pair = 14'h0000;
      endcase
      return pair;
   endfunction

   function automatic logic [6:0] key_char(input logic [6:0] code, input logic shift);
      logic [13:0] pair;
      pair = key_pair(code);
      return shift ? pair[6:0] : pair[13:7];
   endfunction

endpackage

`default_nettype wire

@@ sv/scan_set1_key_decoder.sv @@
// Scan code set 1 key decoder: prefix tracking, key events, keymap lookup.
// Depends on sskd_pkg and assert_macros.svh.
//
// Takes one scan code byte per transaction and returns at most one key event
// per byte. A byte can be accepted every cycle unless the output is stalled;
// its event, if any, shows on the rsp_ side in the cycle after acceptance.
// The single output register sets the rate: a new byte is taken whenever it is
// empty or drained in the same cycle, so while rsp_ready holds high the rate is
// one byte per cycle. E0 marks the next event as extended, E1 swallows the five
// bytes after it, and filler bytes (00, AA, EE, FA, FC-FF) produce no event.
`default_nettype none

`include "assert_macros.svh"

module scan_set1_key_decoder (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  sskd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output sskd_pkg::rsp_type rsp_data
);

   sskd_pkg::phase_type phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sskd_pkg::rsp_type   rsp_data_ff;
   logic                accept;
   logic                emit;
   logic                ext;
   logic                ignored;
   logic                in_pause;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign ignored   = sskd_pkg::is_ignored(req_data.scan_byte);
   assign in_pause  = (phase_ff == sskd_pkg::PH_P5) || (phase_ff == sskd_pkg::PH_P4) ||
                      (phase_ff == sskd_pkg::PH_P3) || (phase_ff == sskd_pkg::PH_P2) ||
                      (phase_ff == sskd_pkg::PH_P1);

   always_comb begin
      phase_in = phase_ff;
      emit     = 1'b0;
      ext      = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            sskd_pkg::PH_EXT: begin
               phase_in = sskd_pkg::PH_IDLE;
               emit     = !ignored;
               ext      = 1'b1;
            end
            sskd_pkg::PH_P5: phase_in = sskd_pkg::PH_P4;
            sskd_pkg::PH_P4: phase_in = sskd_pkg::PH_P3;
            sskd_pkg::PH_P3: phase_in = sskd_pkg::PH_P2;
            sskd_pkg::PH_P2: phase_in = sskd_pkg::PH_P1;
            sskd_pkg::PH_P1: phase_in = sskd_pkg::PH_IDLE;
            default: begin
               phase_in = sskd_pkg::PH_IDLE;
               priority if (ignored) begin
                  emit = 1'b0;
               end else if (req_data.scan_byte == sskd_pkg::EXT_PREFIX) begin
                  phase_in = sskd_pkg::PH_EXT;
               end else if (req_data.scan_byte == sskd_pkg::PAUSE_PREFIX) begin
                  phase_in = sskd_pkg::PH_P5;
               end else begin
                  emit = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sskd_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff.key_code    <= req_data.scan_byte[6:0];
         rsp_data_ff.is_extended <= ext;
         rsp_data_ff.is_press    <= !req_data.scan_byte[7];
         rsp_data_ff.ascii_char  <= sskd_pkg::key_char(req_data.scan_byte[6:0],
                                                       req_data.shift_held);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SSKD_ASSERT(a_rsp_from_accept, $rose(rsp_valid_ff) |-> $past(accept), "event without transaction")
   `SSKD_ASSERT(a_pause_silent, (accept && in_pause) |=> !rsp_valid_ff, "event inside pause")
   `SSKD_ASSERT(a_ext_arm, (accept && (phase_ff == sskd_pkg::PH_IDLE) && (req_data.scan_byte == sskd_pkg::EXT_PREFIX)) |=> (phase_ff == sskd_pkg::PH_EXT), "prefix not armed")

endmodule

`default_nettype wire
